[design/lvre_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lvre_pkg;

    // Width of the plane position counter.
    localparam int PLANE_POS_WIDTH = 24;
    // Width of the plane size register.
    localparam int PLANE_SIZE_WIDTH = 25;
    // Width used to compare the incremented position with the plane size.
    localparam int PLANE_CMP_WIDTH = (PLANE_POS_WIDTH + 1 > PLANE_SIZE_WIDTH) ?
                                     PLANE_POS_WIDTH + 1 : PLANE_SIZE_WIDTH;

    localparam logic [7:0] RUN_MAX = 8'd255;

    // Configuration port.
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;
    localparam logic [PADDR_WIDTH-1:0] ADDR_PLANE_SIZE = 3'd0;
    localparam logic [PLANE_SIZE_WIDTH-1:0] PLANE_SIZE_RESET = 25'd1;

    // Output queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_WIDTH = 2;
    localparam int QUEUE_CNT_WIDTH = 3;

    typedef struct packed {
        logic [7:0] run_count;
        logic [7:0] run_label;
        logic       ends_plane;
        logic       last_of_item;
    } run_t;

    // Runs produced by one voxel, packed to the front.
    typedef struct packed {
        logic [1:0] num_runs;
        run_t       run_first;
        run_t       run_second;
    } run_push_t;

endpackage

`default_nettype wire

[design/label_volume_rle_encoder_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Run-length encoder for a stream of 8-bit label voxels in raster order.
// Each word on the input channel (s_valid/s_ready, s_voxel_label) carries
// one voxel. Each word on the result channel (m_valid/m_ready) carries one
// run: its count, its label, whether the plane boundary closed it, and a
// flag on the final run caused by a given voxel. A voxel gives zero, one or
// two runs. The plane size (voxels per plane) is set through the APB-style
// register at byte address 0 and should only be written while idle.
// A voxel is taken into an input register and is processed by the run tracker
// once the output queue is sure to have room; its runs are written into that
// queue, whose head drives the result channel. The run tracker takes one voxel
// per cycle while the queue has room for two runs; the result channel delivers
// one run per cycle while the receiver is ready, so a voxel that yields two
// runs costs one extra result slot, absorbed by the four-word output queue.
// When the receiver stalls, the queue fills and s_ready drops once it holds
// more than two words. Reset clears the open run and plane position, empties
// the queue and sets the plane size to 1.
module label_volume_rle_encoder_core
    import lvre_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [7:0]             s_voxel_label,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_run_count,
    output logic [7:0]                  m_run_label,
    output logic                        m_ends_plane,
    output logic                        m_last_of_item,

    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_WIDTH-1:0] paddr,
    input  wire logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0]      prdata,
    output logic                        pready
);

    // Plane size register, written through the configuration port.
    logic [PLANE_SIZE_WIDTH-1:0] plane_size_reg;

    // Input register: the voxel waiting for the run tracker.
    logic       in_valid_reg;
    logic [7:0] in_label_reg;

    logic                       step_en;
    logic [QUEUE_CNT_WIDTH-1:0] queue_fill;
    run_push_t                  push;
    run_t                       out_run;

    // The tracker may run only when the queue is sure to have room for two
    // runs, judged from its registered fill so no path comes from m_ready.
    assign step_en = in_valid_reg
                     && (queue_fill <= QUEUE_CNT_WIDTH'(QUEUE_DEPTH - 2));
    assign s_ready = !in_valid_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_label_reg <= s_voxel_label;
        end
    end

    // Configuration port: a write lands in the access phase; other addresses
    // are ignored and read back as zero.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_size_reg <= PLANE_SIZE_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_PLANE_SIZE)) begin
            plane_size_reg <= pwdata[PLANE_SIZE_WIDTH-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_PLANE_SIZE) begin
            prdata = PDATA_WIDTH'(plane_size_reg);
        end
    end

    lvre_run_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .voxel_label (in_label_reg),
        .plane_size  (plane_size_reg),
        .push        (push)
    );

    // Nothing is pushed on cycles where the tracker does not step.
    run_push_t queue_push;

    always_comb begin
        queue_push = push;
        if (!step_en) begin
            queue_push.num_runs = 2'd0;
        end
    end

    lvre_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_push),
        .fill      (queue_fill),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_run   (out_run)
    );

    assign m_run_count    = out_run.run_count;
    assign m_run_label    = out_run.run_label;
    assign m_ends_plane   = out_run.ends_plane;
    assign m_last_of_item = out_run.last_of_item;

endmodule

`default_nettype wire

[design/lvre_run_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lvre_run_tracker
    import lvre_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        step_en,
    input  wire logic [7:0]                  voxel_label,
    input  wire logic [PLANE_SIZE_WIDTH-1:0] plane_size,
    output run_push_t                        push
);

    logic [7:0]                 open_len_reg, open_len_next;
    logic [7:0]                 open_label_reg, open_label_next;
    logic [PLANE_POS_WIDTH-1:0] plane_pos_reg, plane_pos_next;

    logic [7:0]               len_after_voxel;
    logic [7:0]               len_inc;
    logic                     emit_change;
    run_t                     run_change;
    run_t                     run_plane;
    logic                     emit_plane;
    logic [PLANE_POS_WIDTH:0] pos_inc;
    logic                     at_boundary;

    always_comb begin
        len_inc         = open_len_reg + 8'd1;
        emit_change     = 1'b0;
        run_change      = '{run_count: open_len_reg, run_label: open_label_reg,
                            ends_plane: 1'b0, last_of_item: 1'b0};
        len_after_voxel = 8'd1;
        open_label_next = voxel_label;

        if (open_len_reg == 8'd0) begin
            len_after_voxel = 8'd1;
        end else if (open_label_reg == voxel_label) begin
            // Same label: extend, and close the run when it is full.
            if (len_inc == RUN_MAX) begin
                emit_change          = 1'b1;
                run_change.run_count = RUN_MAX;
                len_after_voxel      = 8'd0;
            end else begin
                len_after_voxel = len_inc;
            end
        end else begin
            emit_change = 1'b1;
        end

        pos_inc     = {1'b0, plane_pos_reg} + {{PLANE_POS_WIDTH{1'b0}}, 1'b1};
        at_boundary = (PLANE_CMP_WIDTH'(pos_inc) == PLANE_CMP_WIDTH'(plane_size));

        emit_plane = at_boundary && (len_after_voxel != 8'd0);
        run_plane  = '{run_count: len_after_voxel, run_label: open_label_next,
                       ends_plane: 1'b1, last_of_item: 1'b1};

        if (at_boundary) begin
            plane_pos_next = '0;
            open_len_next  = 8'd0;
        end else begin
            plane_pos_next = pos_inc[PLANE_POS_WIDTH-1:0];
            open_len_next  = len_after_voxel;
        end

        run_change.last_of_item = !emit_plane;

        push.num_runs   = {1'b0, emit_change} + {1'b0, emit_plane};
        push.run_first  = emit_change ? run_change : run_plane;
        push.run_second = run_plane;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_len_reg   <= 8'd0;
            open_label_reg <= 8'd0;
            plane_pos_reg  <= '0;
        end else if (step_en) begin
            open_len_reg   <= open_len_next;
            open_label_reg <= open_label_next;
            plane_pos_reg  <= plane_pos_next;
        end
    end

endmodule

`default_nettype wire

[design/lvre_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module lvre_out_queue
    import lvre_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire run_push_t                  push,
    output logic [QUEUE_CNT_WIDTH-1:0]      fill,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output run_t                            out_run
);

    run_t                        entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_WIDTH-1:0]  count_reg, count_next;
    logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_plus1;
    logic                        pop;

    assign out_valid    = (count_reg != '0);
    assign out_run      = entry_reg[rd_ptr_reg];
    assign fill         = count_reg;
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_WIDTH'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_WIDTH'(push.num_runs);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_WIDTH'(pop);
        count_next  = count_reg + QUEUE_CNT_WIDTH'(push.num_runs)
                      - QUEUE_CNT_WIDTH'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.num_runs != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.run_first;
        end
        if (push.num_runs == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push.run_second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire
